[design/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Types and constants shared by the motor start-up sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_CUR_W  = 16;
    localparam int CFG_TH_W   = 32;
    localparam int CFG_WAIT_W = 24;
    localparam int CFG_TMO_W  = 16;
    localparam int TICK_W     = 32;
    localparam int FLAG_W     = 4;
    localparam int MODE_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_CUR_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_CUR_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THETA_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THETA_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIX_WAIT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RL_ENABLE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT  = 3'd6;

    // register reset values
    localparam logic [CFG_CUR_W-1:0]  RST_ALIGN_CUR_MAX  = 16'd512;
    localparam logic [CFG_CUR_W-1:0]  RST_ALIGN_CUR_STEP = 16'd1;
    localparam logic [CFG_TH_W-1:0]   RST_THETA_START    = 32'd0;
    localparam logic [CFG_TH_W-1:0]   RST_THETA_STEP     = 32'd0;
    localparam logic [CFG_WAIT_W-1:0] RST_FIX_WAIT       = 24'd80000;
    localparam logic                  RST_RL_ENABLE      = 1'b0;
    localparam logic [CFG_TMO_W-1:0]  RST_TIMEOUT_LIMIT  = 16'd0;

    // fault flag bit positions
    localparam int FLAG_DRIVER   = 0;
    localparam int FLAG_ROLLOVER = 1;
    localparam int FLAG_TIMEOUT  = 2;
    localparam int FLAG_INDEX    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 3'd0,
        MODE_RL    = 3'd1,
        MODE_RAMP  = 3'd2,
        MODE_HOLD  = 3'd3,
        MODE_READY = 3'd4,
        MODE_STOP  = 3'd5,
        MODE_ERROR = 3'd6
    } t_mode;

    typedef struct packed {
        logic [CFG_CUR_W-1:0]  align_current_max;
        logic [CFG_CUR_W-1:0]  align_current_step;
        logic [CFG_TH_W-1:0]   theta_align_start;
        logic [CFG_TH_W-1:0]   theta_align_step;
        logic [CFG_WAIT_W-1:0] fix_wait_ticks;
        logic                  rl_estimation_enable;
        logic [CFG_TMO_W-1:0]  timeout_limit;
    } t_cfg;

endpackage

`default_nettype wire

[design/motor_startup_sequencer.sv]
// ----------------------------------------------------------------------------
// motor_startup_sequencer
// Per-tick motor start-up sequencer with fault latching and alignment ramp.
// ----------------------------------------------------------------------------
// One request per control tick enters on i_valid/o_ready and is accepted at a
// clock edge where both are high. It lands in an input register; the next
// edge at which the result register is free evaluates faults and the state
// step and loads the result, raising o_valid at that edge.
// Throughput is one request per cycle while i_ready is high; the single
// mode/ramp/counter register set feeds back, so requests are handled in order.
// When the receiver holds i_ready low, the finished result stays on the
// outputs and one more request is still taken into the input register;
// o_ready then drops until the result is taken.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the
// edge they are presented; the user must make them while no request is in
// flight, as the block does not enforce it. Reset (i_rst_n low, synchronous)
// empties both registers, returns to the init state with ramp, angle, counter
// and fault latch cleared, and loads the default settings.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_startup_sequencer #(
    parameter int CURRENT_WIDTH = 16,
    parameter int THETA_WIDTH   = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // config
    input  wire                                   i_cfg_we,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire                                   i_system_enable,
    input  wire                                   i_motor_enable,
    input  wire                                   i_rollover_check_enable,
    input  wire                                   i_driver_fault,
    input  wire                                   i_rollover_error,
    input  wire                                   i_index_detected,
    input  wire                                   i_index_error,
    input  wire logic [mss_pkg::CFG_TMO_W-1:0]    i_timeout_count,
    input  wire                                   i_rl_done,
    // result channel
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic [mss_pkg::MODE_W-1:0]            o_state_code,
    output logic [mss_pkg::FLAG_W-1:0]            o_error_flags,
    output logic [mss_pkg::CFG_CUR_W-1:0]         o_d_current_ref,
    output logic                                  o_theta_override_valid,
    output logic signed [mss_pkg::CFG_TH_W-1:0]   o_theta_override,
    output logic                                  o_encoder_periph_reset,
    output logic                                  o_encoder_state_reset,
    output logic                                  o_run_current_loop,
    output logic                                  o_force_stop,
    output logic [mss_pkg::TICK_W-1:0]            o_iteration_count
);

    localparam int CurExtW = (CURRENT_WIDTH > mss_pkg::CFG_CUR_W) ?
                             CURRENT_WIDTH : mss_pkg::CFG_CUR_W;

    mss_pkg::t_cfg cfg;

    mss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    logic                           r_in_valid;
    logic                           r_sys_en;
    logic                           r_mot_en;
    logic                           r_roll_chk;
    logic                           r_drv;
    logic                           r_roll_err;
    logic                           r_idx_det;
    logic                           r_idx_err;
    logic [mss_pkg::CFG_TMO_W-1:0]  r_tmo;
    logic                           r_rl_done;

    // state and result registers
    logic                           r_out_valid;
    mss_pkg::t_mode                 r_mode;
    logic [mss_pkg::FLAG_W-1:0]     r_flags;
    logic [CURRENT_WIDTH-1:0]       r_acc;
    logic [THETA_WIDTH-1:0]         r_theta_tot;
    logic [mss_pkg::TICK_W-1:0]     r_tick;
    logic                           r_th_valid;
    logic [THETA_WIDTH-1:0]         r_th_val;
    logic                           r_periph_rst;
    logic                           r_state_rst;
    logic                           r_run;
    logic                           r_stop;

    mss_pkg::t_mode                 n_mode;
    logic [mss_pkg::FLAG_W-1:0]     n_flags;
    logic [CURRENT_WIDTH-1:0]       n_acc;
    logic [THETA_WIDTH-1:0]         n_theta_tot;
    logic [mss_pkg::TICK_W-1:0]     n_tick;
    logic                           n_th_valid;
    logic [THETA_WIDTH-1:0]         n_th_val;
    logic                           n_periph_rst;
    logic                           n_state_rst;
    logic                           n_run;
    logic                           n_stop;

    logic                           out_free;
    logic                           advance;
    mss_pkg::t_mode                 cur_mode;
    logic [CurExtW-1:0]             cmax_ext;
    logic [CurExtW-1:0]             step_ext;
    logic [CURRENT_WIDTH-1:0]       cmax;
    logic [CURRENT_WIDTH:0]         acc_sum;
    logic [CURRENT_WIDTH-1:0]       acc_sat;
    logic [mss_pkg::TICK_W-1:0]     tick_inc;
    logic [THETA_WIDTH-1:0]         theta_sum;
    logic                           enabled;
    logic [CurExtW-1:0]             acc_out;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sys_en   <= i_system_enable;
            r_mot_en   <= i_motor_enable;
            r_roll_chk <= i_rollover_check_enable;
            r_drv      <= i_driver_fault;
            r_roll_err <= i_rollover_error;
            r_idx_det  <= i_index_detected;
            r_idx_err  <= i_index_error;
            r_tmo      <= i_timeout_count;
            r_rl_done  <= i_rl_done;
        end
    end

    // fault flags and shared arithmetic
    always_comb begin
        n_flags = '0;
        n_flags[mss_pkg::FLAG_DRIVER]   = r_drv;
        n_flags[mss_pkg::FLAG_ROLLOVER] = r_roll_err && r_roll_chk;
        n_flags[mss_pkg::FLAG_TIMEOUT]  = (cfg.timeout_limit != '0) &&
                                          (r_tmo > cfg.timeout_limit);
        n_flags[mss_pkg::FLAG_INDEX]    = r_idx_det && r_idx_err;

        cur_mode  = (n_flags != '0) ? mss_pkg::MODE_ERROR : r_mode;
        cmax_ext  = CurExtW'(cfg.align_current_max);
        step_ext  = CurExtW'(cfg.align_current_step);
        cmax      = cmax_ext[CURRENT_WIDTH-1:0];
        acc_sum   = {1'b0, r_acc} + {1'b0, step_ext[CURRENT_WIDTH-1:0]};
        acc_sat   = acc_sum[CURRENT_WIDTH] ? {CURRENT_WIDTH{1'b1}} :
                                             acc_sum[CURRENT_WIDTH-1:0];
        tick_inc  = (&r_tick) ? r_tick : r_tick + 1'b1;
        theta_sum = r_theta_tot + cfg.theta_align_step[THETA_WIDTH-1:0];
        enabled   = r_sys_en && r_mot_en;
    end

    // next state and strobes
    always_comb begin
        n_mode       = mss_pkg::MODE_INIT;
        n_acc        = r_acc;
        n_theta_tot  = r_theta_tot;
        n_tick       = r_tick;
        n_th_valid   = 1'b0;
        n_th_val     = '0;
        n_periph_rst = 1'b0;
        n_state_rst  = 1'b0;
        n_run        = 1'b0;
        n_stop       = 1'b0;

        unique case (cur_mode)
            mss_pkg::MODE_RL: begin
                n_tick = tick_inc;
                n_mode = r_rl_done ? mss_pkg::MODE_RAMP : mss_pkg::MODE_RL;
                if (!enabled) begin
                    n_mode = mss_pkg::MODE_INIT;
                end
                n_periph_rst = r_rl_done;
                n_state_rst  = r_rl_done;
                n_run        = r_rl_done;
            end
            mss_pkg::MODE_RAMP: begin
                n_tick      = '0;
                n_acc       = acc_sat;
                n_theta_tot = theta_sum;
                n_mode      = (acc_sat < cmax) ? mss_pkg::MODE_RAMP : mss_pkg::MODE_HOLD;
                if (!enabled) begin
                    n_mode = mss_pkg::MODE_INIT;
                end
                if (n_mode != mss_pkg::MODE_RAMP) begin
                    n_state_rst = 1'b1;
                end else begin
                    n_th_valid = 1'b1;
                    n_th_val   = cfg.theta_align_start[THETA_WIDTH-1:0] - theta_sum;
                end
                n_run = 1'b1;
            end
            mss_pkg::MODE_HOLD: begin
                n_tick = tick_inc;
                n_acc  = cmax;
                n_mode = (tick_inc < mss_pkg::TICK_W'(cfg.fix_wait_ticks)) ?
                         mss_pkg::MODE_HOLD : mss_pkg::MODE_READY;
                if (!enabled) begin
                    n_mode = mss_pkg::MODE_INIT;
                end
                n_periph_rst = 1'b1;
                n_state_rst  = 1'b1;
                n_run        = 1'b1;
            end
            mss_pkg::MODE_READY, mss_pkg::MODE_STOP: begin
                n_tick = tick_inc;
                n_acc  = '0;
                n_mode = r_mot_en ? mss_pkg::MODE_READY : mss_pkg::MODE_STOP;
                if (!r_sys_en) begin
                    n_mode = mss_pkg::MODE_INIT;
                end
                n_run = 1'b1;
            end
            mss_pkg::MODE_ERROR: begin
                n_acc  = '0;
                n_mode = mss_pkg::MODE_ERROR;
                n_stop = 1'b1;
            end
            default: begin
                n_tick = '0;
                n_acc  = '0;
                if (!r_sys_en || !r_mot_en) begin
                    n_mode = mss_pkg::MODE_INIT;
                end else if (cfg.rl_estimation_enable) begin
                    n_mode = mss_pkg::MODE_RL;
                end else begin
                    n_mode = mss_pkg::MODE_RAMP;
                end
                n_periph_rst = 1'b1;
                n_stop       = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= mss_pkg::MODE_INIT;
            r_flags     <= '0;
            r_acc       <= '0;
            r_theta_tot <= '0;
            r_tick      <= '0;
        end else if (advance) begin
            r_mode      <= n_mode;
            r_flags     <= n_flags;
            r_acc       <= n_acc;
            r_theta_tot <= n_theta_tot;
            r_tick      <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_th_valid   <= n_th_valid;
            r_th_val     <= n_th_val;
            r_periph_rst <= n_periph_rst;
            r_state_rst  <= n_state_rst;
            r_run        <= n_run;
            r_stop       <= n_stop;
        end
    end

    assign acc_out = CurExtW'(r_acc);

    assign o_valid                = r_out_valid;
    assign o_state_code           = r_mode;
    assign o_error_flags          = r_flags;
    assign o_d_current_ref        = acc_out[mss_pkg::CFG_CUR_W-1:0];
    assign o_theta_override_valid = r_th_valid;
    assign o_theta_override       = mss_pkg::CFG_TH_W'($signed(r_th_val));
    assign o_encoder_periph_reset = r_periph_rst;
    assign o_encoder_state_reset  = r_state_rst;
    assign o_run_current_loop     = r_run;
    assign o_force_stop           = r_stop;
    assign o_iteration_count      = r_tick;

`ifndef ASSERT_OFF
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == mss_pkg::MODE_ERROR |=> r_mode == mss_pkg::MODE_ERROR)
        else $error("error state left without reset");

    a_theta_in_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_theta_override_valid |->
            o_state_code == mss_pkg::MODE_RAMP)
        else $error("forced angle outside alignment ramp");

    a_run_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_run_current_loop && o_force_stop))
        else $error("current loop run together with force stop");

    a_fault_to_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_flags != '0) |-> o_state_code == mss_pkg::MODE_ERROR)
        else $error("fault latched without error state");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid)
        else $error("stalled request dropped");
`endif

endmodule

`default_nettype wire

[design/mss_cfg.sv]
// ----------------------------------------------------------------------------
// mss_cfg
// Configuration register file: decodes writes and holds the settings.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mss_pkg::t_cfg                         o_cfg
);

    mss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.align_current_max    <= mss_pkg::RST_ALIGN_CUR_MAX;
            r_cfg.align_current_step   <= mss_pkg::RST_ALIGN_CUR_STEP;
            r_cfg.theta_align_start    <= mss_pkg::RST_THETA_START;
            r_cfg.theta_align_step     <= mss_pkg::RST_THETA_STEP;
            r_cfg.fix_wait_ticks       <= mss_pkg::RST_FIX_WAIT;
            r_cfg.rl_estimation_enable <= mss_pkg::RST_RL_ENABLE;
            r_cfg.timeout_limit        <= mss_pkg::RST_TIMEOUT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mss_pkg::REG_ALIGN_CUR_MAX: begin
                    r_cfg.align_current_max <= i_cfg_data[mss_pkg::CFG_CUR_W-1:0];
                end
                mss_pkg::REG_ALIGN_CUR_STEP: begin
                    r_cfg.align_current_step <= i_cfg_data[mss_pkg::CFG_CUR_W-1:0];
                end
                mss_pkg::REG_THETA_START: begin
                    r_cfg.theta_align_start <= i_cfg_data[mss_pkg::CFG_TH_W-1:0];
                end
                mss_pkg::REG_THETA_STEP: begin
                    r_cfg.theta_align_step <= i_cfg_data[mss_pkg::CFG_TH_W-1:0];
                end
                mss_pkg::REG_FIX_WAIT: begin
                    r_cfg.fix_wait_ticks <= i_cfg_data[mss_pkg::CFG_WAIT_W-1:0];
                end
                mss_pkg::REG_RL_ENABLE: begin
                    r_cfg.rl_estimation_enable <= i_cfg_data[0];
                end
                mss_pkg::REG_TIMEOUT_LIMIT: begin
                    r_cfg.timeout_limit <= i_cfg_data[mss_pkg::CFG_TMO_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
